// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is off while reset is held.
`define FMX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked through reset as well.
`define FMX_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fmx_pkg.sv =====
// ----------------------------------------------------------------------------
// FM stereo encoder package
// Shared constants, codes, control types and small tables of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fmx_pkg;

  localparam int DEF_TAP_COUNT    = 32;
  localparam int DEF_PHASE_COUNT  = 32;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_COEF_WIDTH   = 18;

  localparam int CFG_W   = 22;
  localparam int CFG_IW  = 2;
  localparam int POS_W   = 24;
  localparam int ENV_W   = 32;
  localparam int MPX_W   = 24;
  localparam int IDX_W   = 10;
  localparam int MAX_OUT = 32;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam logic [CFG_W-1:0] RATIO_MIN   = 22'd65536;
  localparam logic [CFG_W-1:0] RATIO_MAX   = 22'd2097152;
  localparam logic [CFG_W-1:0] RATIO_RESET = 22'd338826;
  localparam logic [CFG_W-1:0] SCALE_RESET = 22'd405635;
  localparam logic [POS_W-1:0] POS_STEP    = 24'd65536;

  localparam logic [ENV_W-1:0] ENV_ONE    = 32'd16777216;
  localparam logic [ENV_W-1:0] DECAY_Q32  = 32'd4294945821;
  localparam logic [ENV_W-1:0] GAIN_FLOOR = 32'd167772;

  localparam logic signed [19:0] SUM_GAIN  = 20'sd265421;
  localparam logic signed [19:0] DIFF_GAIN = 20'sd229861;
  localparam int ROUND_HALF = 32768;
  localparam int MPX_MAX    = 8388607;
  localparam int MPX_MIN    = -8388608;

  // Input word codes
  localparam logic CMD_COEF  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_RATIO  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SCALE  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_STEREO = 2'd2;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_CHECK,
    SEQ_PHASE,
    SEQ_MAC,
    SEQ_MIX,
    SEQ_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    MIX_IDLE,
    MIX_ENV,
    MIX_JOIN,
    MIX_DIV,
    MIX_MULT,
    MIX_SUM
  } mix_state_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic mul;
    logic acc_en;
    logic clr;
  } lane_ctrl_t;

  // 0.9 * sin(step * 30 degrees) in Q18
  function automatic logic signed [19:0] pilot_value(input logic [3:0] step);
    logic signed [19:0] v;
    case (step)
      4'd0:    v = 20'sd0;
      4'd1:    v = 20'sd117965;
      4'd2:    v = 20'sd204321;
      4'd3:    v = 20'sd235930;
      4'd4:    v = 20'sd204321;
      4'd5:    v = 20'sd117965;
      4'd6:    v = 20'sd0;
      4'd7:    v = -20'sd117965;
      4'd8:    v = -20'sd204321;
      4'd9:    v = -20'sd235930;
      4'd10:   v = -20'sd204321;
      4'd11:   v = -20'sd117965;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

  // 38 kHz carrier gain over six steps
  function automatic logic signed [19:0] diff_gain(input logic [2:0] step);
    logic signed [19:0] v;
    case (step)
      3'd1, 3'd2: v = DIFF_GAIN;
      3'd4, 3'd5: v = -DIFF_GAIN;
      default:    v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fmx_fir_lane.sv =====
// ----------------------------------------------------------------------------
// FIR lane
// Sample history ring and a multiply-accumulate over the taps of one phase.
// ----------------------------------------------------------------------------
`default_nettype none

module fmx_fir_lane #(
  parameter int TAPS  = 32,
  parameter int SW    = 16,
  parameter int CW    = 18,
  parameter int ACC_W = 39
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  fmx_pkg::lane_ctrl_t        ctrl,
  input  wire  [$clog2(TAPS)-1:0]    wr_idx,
  input  wire  [$clog2(TAPS)-1:0]    rd_idx,
  input  wire  signed [SW-1:0]       sample,
  input  wire  signed [CW-1:0]       coef,
  output logic signed [ACC_W-1:0]    acc
);
  import fmx_pkg::*;

  localparam int PW = SW + CW;

  logic signed [SW-1:0]    hist_r [TAPS];
  logic signed [SW-1:0]    hq_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) hist_r[i] <= '0;
    end else if (ctrl.wr) begin
      hist_r[wr_idx] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) hq_r <= hist_r[rd_idx];
    if (ctrl.mul) prod_r <= PW'(coef) * PW'(hq_r);
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== hdl/fmx_divider.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fmx_divider #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 33,
  parameter int Q_W   = 20
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  wire  [NUM_W-1:0]  num,
  input  wire  [DEN_W-1:0]  den,
  output logic              done,
  output logic [Q_W-1:0]    quot
);
  import fmx_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qr_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign trial   = {rem_r, qr_r[NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      qr_r  <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qr_r  <= {qr_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = qr_r[Q_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/fmx_mixer.sv =====
// ----------------------------------------------------------------------------
// Envelope compressor and composite mixer
// Merges the two lane sums: peak envelopes, gain division and MPX forming.
// ----------------------------------------------------------------------------
`default_nettype none

module fmx_mixer #(
  parameter int ACC_W    = 39,
  parameter int ACC_FRAC = 30
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire                              stereo,
  input  wire  [ACC_W-1:0]                 acc_l,
  input  wire  [ACC_W-1:0]                 acc_r,
  output logic                             done,
  output logic signed [fmx_pkg::MPX_W-1:0] mpx
);
  import fmx_pkg::*;

  localparam int M24_W = (ACC_FRAC < 24) ? ACC_W + 24 - ACC_FRAC : ACC_W;
  localparam int SAT_W = (M24_W > ENV_W) ? M24_W : ENV_W + 1;
  localparam int NUM_W = (ACC_FRAC <= 42) ? ACC_W + 42 - ACC_FRAC : ACC_W - (ACC_FRAC - 42);
  localparam int DEN_W = ENV_W + 1;
  localparam int Q_W   = (NUM_W - 31 > 20) ? NUM_W - 31 : 20;
  localparam int Y_W   = Q_W + 1;
  localparam int S_W   = Y_W + 1;
  localparam int P_W   = S_W + 20;

  mix_state_t state_r, state_nxt;
  logic env_we, join_we, div_start, mult_we, sum_we;

  logic                   stereo_r;
  logic [ENV_W-1:0]       env_r  [2];
  logic [ACC_W-1:0]       mag_r  [2];
  logic                   neg_r  [2];
  logic [ACC_W-1:0]       acc_u  [2];
  logic [ACC_W-1:0]       mag_c  [2];
  logic [ENV_W-1:0]       env_c  [2];
  logic [NUM_W-1:0]       num_c  [2];
  logic [DEN_W-1:0]       den_c  [2];
  logic [Q_W-1:0]         quot   [2];
  logic                   div_done [2];
  logic signed [Y_W-1:0]  y_c    [2];
  logic [ENV_W-1:0]       joined;
  logic [3:0]             pilot_r;
  logic [2:0]             sub_r;
  logic                   done_r;
  logic signed [MPX_W-1:0] mpx_r;

  logic signed [S_W-1:0]  s_c, d_c;
  logic signed [P_W-1:0]  p1_c, p2_c, p1_r, p2_r;
  logic signed [P_W:0]    t_c, sh_c, v_c;
  logic signed [MPX_W-1:0] sat_c;

  assign acc_u[0] = acc_l;
  assign acc_u[1] = acc_r;
  assign joined   = (env_r[0] > env_r[1]) ? env_r[0] : env_r[1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [M24_W-1:0]   m24w;
    logic [SAT_W-1:0]   m24x;
    logic [ENV_W-1:0]   m24;
    logic [2*ENV_W-1:0] dec_prod;

    assign mag_c[l] = acc_u[l][ACC_W-1] ? (~acc_u[l] + 1'b1) : acc_u[l];

    if (ACC_FRAC >= 24) begin : g_down
      assign m24w = M24_W'(mag_c[l] >> (ACC_FRAC - 24));
    end else begin : g_up
      assign m24w = M24_W'(mag_c[l]) << (24 - ACC_FRAC);
    end

    assign m24x     = SAT_W'(m24w);
    assign m24      = (m24x[SAT_W-1:ENV_W] != '0) ? '1 : m24x[ENV_W-1:0];
    assign dec_prod = (2*ENV_W)'(env_r[l]) * (2*ENV_W)'(DECAY_Q32);
    assign env_c[l] = (m24 > env_r[l]) ? m24 : dec_prod[2*ENV_W-1:ENV_W];

    if (ACC_FRAC <= 42) begin : g_num_up
      assign num_c[l] = NUM_W'(mag_r[l]) << (42 - ACC_FRAC);
    end else begin : g_num_down
      assign num_c[l] = NUM_W'(mag_r[l] >> (ACC_FRAC - 42));
    end

    assign den_c[l] = DEN_W'(stereo_r ? joined : env_r[l]) + DEN_W'(GAIN_FLOOR);

    fmx_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (Q_W)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   (num_c[l]),
      .den   (den_c[l]),
      .done  (div_done[l]),
      .quot  (quot[l])
    );

    assign y_c[l] = neg_r[l] ? -$signed({1'b0, quot[l]}) : $signed({1'b0, quot[l]});
  end

  assign s_c  = S_W'(y_c[0]) + S_W'(y_c[1]);
  assign d_c  = S_W'(y_c[0]) - S_W'(y_c[1]);
  assign p1_c = stereo_r ? P_W'(s_c) * P_W'(SUM_GAIN)
                         : (P_W'(y_c[0]) <<< 3) + P_W'(y_c[0]);
  assign p2_c = stereo_r ? P_W'(d_c) * P_W'(diff_gain(sub_r)) : '0;

  // Rounding to the nearest with halves up is a floor after adding one half.
  assign t_c  = (P_W+1)'(p1_r) + (P_W+1)'(p2_r) + (P_W+1)'(ROUND_HALF);
  assign sh_c = t_c >>> 16;
  assign v_c  = stereo_r ? sh_c + (P_W+1)'(pilot_value(pilot_r)) : (P_W+1)'(p1_r);

  always_comb begin
    if (v_c > (P_W+1)'(MPX_MAX)) begin
      sat_c = MPX_W'(MPX_MAX);
    end else if (v_c < (P_W+1)'(MPX_MIN)) begin
      sat_c = MPX_W'(MPX_MIN);
    end else begin
      sat_c = v_c[MPX_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    env_we    = 1'b0;
    join_we   = 1'b0;
    div_start = 1'b0;
    mult_we   = 1'b0;
    sum_we    = 1'b0;
    case (state_r)
      MIX_IDLE: begin
        if (start) state_nxt = MIX_ENV;
      end
      MIX_ENV: begin
        env_we    = 1'b1;
        state_nxt = MIX_JOIN;
      end
      MIX_JOIN: begin
        join_we   = 1'b1;
        div_start = 1'b1;
        state_nxt = MIX_DIV;
      end
      MIX_DIV: begin
        if (div_done[0] && div_done[1]) state_nxt = MIX_MULT;
      end
      MIX_MULT: begin
        mult_we   = 1'b1;
        state_nxt = MIX_SUM;
      end
      MIX_SUM: begin
        sum_we    = 1'b1;
        state_nxt = MIX_IDLE;
      end
      default: state_nxt = MIX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= MIX_IDLE;
      done_r   <= 1'b0;
      env_r[0] <= ENV_ONE;
      env_r[1] <= ENV_ONE;
      pilot_r  <= '0;
      sub_r    <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= sum_we;
      if (env_we) begin
        env_r[0] <= env_c[0];
        if (stereo_r) env_r[1] <= env_c[1];
      end
      if (join_we && stereo_r) begin
        env_r[0] <= joined;
        env_r[1] <= joined;
      end
      if (sum_we && stereo_r) begin
        pilot_r <= (pilot_r == 4'd11) ? 4'd0 : pilot_r + 4'd1;
        sub_r   <= (sub_r == 3'd5) ? 3'd0 : sub_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == MIX_IDLE) stereo_r <= stereo;
    if (env_we) begin
      for (int l = 0; l < 2; l++) begin
        mag_r[l] <= mag_c[l];
        neg_r[l] <= acc_u[l][ACC_W-1];
      end
    end
    if (mult_we) begin
      p1_r <= p1_c;
      p2_r <= p2_c;
    end
    if (sum_we) mpx_r <= sat_c;
  end

  assign done = done_r;
  assign mpx  = mpx_r;

endmodule

`default_nettype wire

// ===== hdl/fm_stereo_mpx_encoder_top.sv =====
// ----------------------------------------------------------------------------
// FM stereo multiplex encoder
// Polyphase upsampler with two FIR lanes, peak compressor and MPX mixer.
//
// Input channel (in_*): one word is either a filter coefficient load
// (in_cmd = 0) or an audio frame (in_cmd = 1). Coefficients must be loaded
// before frames that use them. Output channel (out_*): composite samples in
// Q5.18, with out_last marking the final sample that a frame produces.
// A frame yields zero to 32 samples depending on the position accumulator.
//
// Operation: a coefficient word is written while the sequencer stays idle.
// For a frame, the multiply-accumulate walks the taps one per cycle and
// the gain divider resolves one bit of its 51-bit dividend per cycle for
// each output sample. The next word is taken once the last sample of the
// frame sits in the output register.
// Reset (synchronous, active low) clears histories and carrier steps, sets
// envelopes to ENV_ONE and the position to RATIO_RESET; the coefficient
// memory keeps whatever it held. While out_stall is high a finished sample
// waits in the output register and the next sample is held in SEQ_OUT.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_stereo_mpx_encoder_top #(
  parameter int TAP_COUNT    = fmx_pkg::DEF_TAP_COUNT,
  parameter int PHASE_COUNT  = fmx_pkg::DEF_PHASE_COUNT,
  parameter int SAMPLE_WIDTH = fmx_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = fmx_pkg::DEF_COEF_WIDTH
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_write_en,
  input  wire  [fmx_pkg::CFG_IW-1:0]       cfg_index,
  input  wire  [fmx_pkg::CFG_W-1:0]        cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_cmd,
  input  wire  [fmx_pkg::IDX_W-1:0]        in_coef_index,
  input  wire  signed [COEF_WIDTH-1:0]     in_coef_value,
  input  wire  signed [SAMPLE_WIDTH-1:0]   in_left_sample,
  input  wire  signed [SAMPLE_WIDTH-1:0]   in_right_sample,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [fmx_pkg::MPX_W-1:0] out_mpx_sample,
  output logic                             out_last
);
  import fmx_pkg::*;

  localparam int DEPTH    = PHASE_COUNT * TAP_COUNT;
  localparam int AW       = $clog2(DEPTH);
  localparam int TIW      = $clog2(TAP_COUNT);
  localparam int ACC_W    = SAMPLE_WIDTH + COEF_WIDTH + $clog2(TAP_COUNT);
  localparam int ACC_FRAC = SAMPLE_WIDTH + COEF_WIDTH - 4;
  localparam int PROD_W   = POS_W + CFG_W;
  localparam int PH_W     = PROD_W - 32;

  // Configuration registers
  logic [CFG_W-1:0] ratio_r, scale_r;
  logic             stereo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RATIO_RESET;
      scale_r  <= SCALE_RESET;
      stereo_r <= 1'b1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_RATIO:  ratio_r  <= cfg_data;
        REG_SCALE:  scale_r  <= cfg_data;
        REG_STEREO: stereo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] ratio_c;
  logic [POS_W-1:0] ratio24;

  always_comb begin
    if (ratio_r < RATIO_MIN) begin
      ratio_c = RATIO_MIN;
    end else if (ratio_r > RATIO_MAX) begin
      ratio_c = RATIO_MAX;
    end else begin
      ratio_c = ratio_r;
    end
  end
  assign ratio24 = POS_W'(ratio_c);

  // Sequencer state
  seq_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [TIW-1:0]    ptr_r, ptr_nxt, ptr_wrap;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              frame_st_r, frame_st_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [TIW-1:0]    hidx_r, hidx_nxt;
  logic [TIW-1:0]    tap_r, tap_nxt;
  logic              issue_r, issue_nxt;
  logic              v1_r, v2_r;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [MPX_W-1:0] out_mpx_r, out_mpx_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc;
  logic              coef_we;
  logic              mix_start;
  logic              mix_done;
  logic signed [MPX_W-1:0] mix_mpx;
  lane_ctrl_t        ctrl_l, ctrl_r;
  logic [PH_W-1:0]   ph_raw, ph_sel;
  logic [AW-1:0]     base_c;
  logic [POS_W:0]    pos_after;

  logic signed [COEF_WIDTH-1:0] coef_mem [DEPTH];
  logic signed [COEF_WIDTH-1:0] coef_q_r;
  logic signed [ACC_W-1:0]      acc_l, acc_r;

  assign in_acc    = in_valid && !in_stall;
  assign ptr_wrap  = (ptr_r == TIW'(TAP_COUNT - 1)) ? '0 : ptr_r + 1'b1;
  assign ph_raw    = prod_r[PROD_W-1:32];
  assign ph_sel    = (ph_raw >= PH_W'(PHASE_COUNT)) ? PH_W'(PHASE_COUNT - 2) : ph_raw;
  assign base_c    = AW'(ph_sel) * AW'(TAP_COUNT);
  assign pos_after = (POS_W+1)'(pos_r) + (POS_W+1)'(POS_STEP);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    frame_st_nxt  = frame_st_r;
    prod_nxt      = prod_r;
    addr_nxt      = addr_r;
    hidx_nxt      = hidx_r;
    tap_nxt       = tap_r;
    issue_nxt     = issue_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_mpx_nxt   = out_mpx_r;
    out_last_nxt  = out_last_r;
    coef_we       = 1'b0;
    mix_start     = 1'b0;
    in_stall      = (state_r != SEQ_IDLE);
    ctrl_l        = '0;
    ctrl_l.rd     = issue_r;
    ctrl_l.mul    = v1_r;
    ctrl_l.acc_en = v2_r;

    case (state_r)
      SEQ_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_COEF) begin
            coef_we = (32'(in_coef_index) < DEPTH);
          end else begin
            pos_nxt      = (pos_r >= ratio24) ? pos_r - ratio24 : '0;
            ptr_nxt      = ptr_wrap;
            ctrl_l.wr    = 1'b1;
            frame_st_nxt = stereo_r;
            cnt_nxt      = '0;
            state_nxt    = SEQ_CHECK;
          end
        end
      end
      SEQ_CHECK: begin
        if (pos_r < ratio24 && cnt_r < CNT_W'(MAX_OUT)) begin
          prod_nxt  = PROD_W'(pos_r) * PROD_W'(scale_r);
          last_nxt  = (pos_after >= (POS_W+1)'(ratio24)) || (cnt_r == CNT_W'(MAX_OUT - 1));
          state_nxt = SEQ_PHASE;
        end else begin
          state_nxt = SEQ_IDLE;
        end
      end
      SEQ_PHASE: begin
        addr_nxt   = base_c;
        hidx_nxt   = ptr_r;
        tap_nxt    = '0;
        issue_nxt  = 1'b1;
        ctrl_l.clr = 1'b1;
        state_nxt  = SEQ_MAC;
      end
      SEQ_MAC: begin
        if (issue_r) begin
          addr_nxt = addr_r + 1'b1;
          hidx_nxt = (hidx_r == '0) ? TIW'(TAP_COUNT - 1) : hidx_r - 1'b1;
          tap_nxt  = tap_r + 1'b1;
          if (tap_r == TIW'(TAP_COUNT - 1)) issue_nxt = 1'b0;
        end else if (!v1_r && !v2_r) begin
          mix_start = 1'b1;
          state_nxt = SEQ_MIX;
        end
      end
      SEQ_MIX: begin
        if (mix_done) state_nxt = SEQ_OUT;
      end
      SEQ_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_mpx_nxt   = mix_mpx;
          out_last_nxt  = last_r;
          pos_nxt       = pos_after[POS_W-1:0];
          cnt_nxt       = cnt_r + 1'b1;
          state_nxt     = last_r ? SEQ_IDLE : SEQ_CHECK;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase

    ctrl_r    = ctrl_l;
    ctrl_r.wr = ctrl_l.wr && stereo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      pos_r       <= POS_W'(RATIO_RESET);
      ptr_r       <= '0;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      v1_r        <= issue_r;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_st_r <= frame_st_nxt;
    prod_r     <= prod_nxt;
    addr_r     <= addr_nxt;
    hidx_r     <= hidx_nxt;
    tap_r      <= tap_nxt;
    last_r     <= last_nxt;
    out_mpx_r  <= out_mpx_nxt;
    out_last_r <= out_last_nxt;
  end

  // Coefficient memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[AW'(in_coef_index)] <= in_coef_value;
  end

  always_ff @(posedge clk) begin
    if (issue_r) coef_q_r <= coef_mem[addr_r];
  end

  fmx_fir_lane #(
    .TAPS  (TAP_COUNT),
    .SW    (SAMPLE_WIDTH),
    .CW    (COEF_WIDTH),
    .ACC_W (ACC_W)
  ) u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_l),
    .wr_idx (ptr_wrap),
    .rd_idx (hidx_r),
    .sample (in_left_sample),
    .coef   (coef_q_r),
    .acc    (acc_l)
  );

  fmx_fir_lane #(
    .TAPS  (TAP_COUNT),
    .SW    (SAMPLE_WIDTH),
    .CW    (COEF_WIDTH),
    .ACC_W (ACC_W)
  ) u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl_r),
    .wr_idx (ptr_wrap),
    .rd_idx (hidx_r),
    .sample (in_right_sample),
    .coef   (coef_q_r),
    .acc    (acc_r)
  );

  fmx_mixer #(
    .ACC_W    (ACC_W),
    .ACC_FRAC (ACC_FRAC)
  ) u_mixer (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mix_start),
    .stereo (frame_st_r),
    .acc_l  (acc_l),
    .acc_r  (acc_r),
    .done   (mix_done),
    .mpx    (mix_mpx)
  );

  assign out_valid      = out_valid_r;
  assign out_mpx_sample = out_mpx_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/fmx_checker.sv =====
// ----------------------------------------------------------------------------
// Encoder port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fmx_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              in_cmd,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire  [fmx_pkg::MPX_W-1:0]        out_mpx_sample,
  input wire                              out_last
);
  import fmx_pkg::*;

  `FMX_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> (!out_valid && !in_stall), "not quiet after reset")

  `FMX_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "stalled word dropped")

  `FMX_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_mpx_sample) && $stable(out_last), "stalled word changed")

  // A coefficient load never produces a result word.
  `FMX_ASSERT(a_coef_silent, clk, rst_n, in_valid && !in_stall && in_cmd == CMD_COEF && !out_valid |=> !out_valid, "coefficient load produced a word")

  // An accepted frame always sets in_stall in the following cycle.
  `FMX_ASSERT(a_frame_busy, clk, rst_n, in_valid && !in_stall && in_cmd == CMD_FRAME |=> in_stall, "frame accepted without going busy")

endmodule

bind fm_stereo_mpx_encoder_top fmx_checker u_fmx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_mpx_sample (out_mpx_sample),
  .out_last       (out_last)
);

`default_nettype wire
